// ===== design/telnet_option_refuser_line_framer_unit_defines.svh =====
// Assertion macros used by the port checker of the telnet line framer.
`ifndef TELNET_OPTION_REFUSER_LINE_FRAMER_UNIT_DEFINES_SVH
`define TELNET_OPTION_REFUSER_LINE_FRAMER_UNIT_DEFINES_SVH

// Checks a property on every rising edge of clk while rst_n is high.
`define TOLF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition implies another one in the same cycle.
`define TOLF_ASSERT_IMP(lbl, ante, cons, msg) \
    `TOLF_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ===== design/tolf_pkg.sv =====
package tolf_pkg;

    localparam logic [7:0] B_IAC  = 8'd255;
    localparam logic [7:0] B_WILL = 8'd251;
    localparam logic [7:0] B_WONT = 8'd252;
    localparam logic [7:0] B_DO   = 8'd253;
    localparam logic [7:0] B_DONT = 8'd254;
    localparam logic [7:0] B_LF   = 8'h0a;
    localparam logic [7:0] B_CR   = 8'h0d;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_EOL   = 2'd1;
    localparam logic [1:0] KIND_REPLY = 2'd2;

    typedef struct packed {
        logic       is_data;
        logic       is_reply;
        logic [7:0] verb;
    } cmd_ev_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [6:0] len;
        logic [7:0] verb;
        logic [7:0] opt;
    } result_t;

endpackage

// ===== design/telnet_option_refuser_line_framer_unit.sv =====
// Telnet receive parser that refuses every option and frames text lines. It takes one
// received byte per cycle while not stalled and gives at most one result per byte: a line
// character, an end of line with the line's length, or a refusal reply (WONT or DONT)
// with the option code. A byte is registered in the input register on acceptance, passes
// the command parser and the line framer and lands in the output register, from which
// its result is offered on the output. The sustained rate is one byte per cycle while
// the output does not stall; the parse mode and line position registers advance on each
// step. The input side stalls only when the input register holds a byte and a stalled
// result waits in the output register.
module telnet_option_refuser_line_framer_unit
#(
    parameter int LINE_BYTES = 128
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] out_kind,
    output logic [7:0] data_byte,
    output logic [6:0] line_length,
    output logic [7:0] reply_verb,
    output logic [7:0] reply_option
);

    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [7:0]        s1_byte_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    tolf_pkg::result_t out_res_reg;
    logic              out_free;
    logic              step;
    logic              res_valid;
    tolf_pkg::cmd_ev_t ev;
    tolf_pkg::result_t res;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !out_free;
    assign step     = s1_valid_reg && out_free;

    assign s1_valid_next  = in_stall ? s1_valid_reg : in_valid;
    assign out_valid_next = out_free ? (step && res_valid) : out_valid_reg;

    tolf_cmd_parser u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .rx_byte (s1_byte_reg),
        .ev      (ev)
    );

    tolf_line_framer
    #(
        .LINE_BYTES (LINE_BYTES)
    )
    u_framer
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .rx_byte   (s1_byte_reg),
        .ev        (ev),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_byte_reg <= rx_byte;
        end
        if (step && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_kind     = out_res_reg.kind;
    assign data_byte    = out_res_reg.data;
    assign line_length  = out_res_reg.len;
    assign reply_verb   = out_res_reg.verb;
    assign reply_option = out_res_reg.opt;

endmodule

// ===== design/tolf_cmd_parser.sv =====
module tolf_cmd_parser
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [7:0]         rx_byte,
    output tolf_pkg::cmd_ev_t  ev
);

    localparam logic [2:0] M_NORMAL = 3'd0;
    localparam logic [2:0] M_IAC    = 3'd1;
    localparam logic [2:0] M_WILL   = 3'd2;
    localparam logic [2:0] M_WONT   = 3'd3;
    localparam logic [2:0] M_DO     = 3'd4;
    localparam logic [2:0] M_DONT   = 3'd5;

    logic [2:0] mode_reg;
    logic [2:0] mode_next;

    always_comb
    begin
        mode_next   = M_NORMAL;
        ev.is_data  = 1'b0;
        ev.is_reply = 1'b0;
        ev.verb     = 8'd0;
        case (mode_reg)
            M_IAC:
            begin
                if (rx_byte == tolf_pkg::B_IAC)
                begin
                    ev.is_data = 1'b1;
                end
                else if (rx_byte == tolf_pkg::B_WILL)
                begin
                    mode_next = M_WILL;
                end
                else if (rx_byte == tolf_pkg::B_WONT)
                begin
                    mode_next = M_WONT;
                end
                else if (rx_byte == tolf_pkg::B_DO)
                begin
                    mode_next = M_DO;
                end
                else if (rx_byte == tolf_pkg::B_DONT)
                begin
                    mode_next = M_DONT;
                end
            end
            M_WILL, M_WONT:
            begin
                ev.is_reply = 1'b1;
                ev.verb     = tolf_pkg::B_DONT;
            end
            M_DO, M_DONT:
            begin
                ev.is_reply = 1'b1;
                ev.verb     = tolf_pkg::B_WONT;
            end
            default:
            begin
                if (rx_byte == tolf_pkg::B_IAC)
                begin
                    mode_next = M_IAC;
                end
                else
                begin
                    ev.is_data = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_NORMAL;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
        end
    end

endmodule

// ===== design/tolf_line_framer.sv =====
module tolf_line_framer
#(
    parameter int LINE_BYTES = 128
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [7:0]         rx_byte,
    input  tolf_pkg::cmd_ev_t  ev,
    output logic               res_valid,
    output tolf_pkg::result_t  res
);

    localparam int POS_W = $clog2(LINE_BYTES);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(LINE_BYTES - 1);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [POS_W+6:0] pos_wide;

    assign pos_wide = {7'd0, pos_reg};

    always_comb
    begin
        res_valid = 1'b0;
        res       = '0;
        pos_next  = pos_reg;
        if (ev.is_reply)
        begin
            res_valid = 1'b1;
            res.kind  = tolf_pkg::KIND_REPLY;
            res.verb  = ev.verb;
            res.opt   = rx_byte;
        end
        else if (ev.is_data && rx_byte != tolf_pkg::B_CR)
        begin
            res_valid = 1'b1;
            if (rx_byte == tolf_pkg::B_LF || pos_reg == POS_LAST)
            begin
                res.kind = tolf_pkg::KIND_EOL;
                res.len  = pos_wide[6:0];
                pos_next = '0;
            end
            else
            begin
                res.kind = tolf_pkg::KIND_DATA;
                res.data = rx_byte;
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (step)
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

// ===== design/tolf_port_checker.sv =====
`include "telnet_option_refuser_line_framer_unit_defines.svh"

module tolf_port_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] rx_byte,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] out_kind,
    input logic [7:0] data_byte,
    input logic [6:0] line_length,
    input logic [7:0] reply_verb,
    input logic [7:0] reply_option
);

    logic out_data;
    logic out_eol;
    logic out_reply;

    assign out_data  = out_valid && out_kind == tolf_pkg::KIND_DATA;
    assign out_eol   = out_valid && out_kind == tolf_pkg::KIND_EOL;
    assign out_reply = out_valid && out_kind == tolf_pkg::KIND_REPLY;

    `TOLF_ASSERT_IMP(a_kind_known, out_valid, out_data || out_eol || out_reply,
        "result kind out of range")

    `TOLF_ASSERT_IMP(a_reply_fields, out_reply,
        (reply_verb == tolf_pkg::B_WONT || reply_verb == tolf_pkg::B_DONT)
            && data_byte == 8'd0 && line_length == 7'd0,
        "malformed option reply")

    `TOLF_ASSERT_IMP(a_line_fields, out_data || out_eol,
        reply_verb == 8'd0 && reply_option == 8'd0
            && (out_eol ? data_byte == 8'd0 : line_length == 7'd0),
        "line result carries stray fields")

    `TOLF_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_kind)
        && $stable(data_byte) && $stable(line_length) && $stable(reply_verb)
        && $stable(reply_option),
        "stalled result changed")

    `TOLF_ASSERT(a_in_hold, in_valid && in_stall |=> in_valid && $stable(rx_byte),
        "stalled input item changed")

endmodule

bind telnet_option_refuser_line_framer_unit tolf_port_checker u_port_checker (.*);
